@@ rtl/gtra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gtra_pkg;

  localparam int POS_W  = 32;
  localparam int SYM_W  = 13;
  localparam int IDX_W  = 15;
  localparam int LVL_W  = 3;
  localparam int CFG_W  = 4;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RULE  = 2'd1,
    OP_LEAF  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic {
    REG_COVERAGE    = 1'b0,
    REG_LEVEL_COUNT = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

@@ rtl/gtra_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gtra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/grammar_tuple_random_access_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Random access into text held as a fixed-tuple grammar. Every beat on the
// input side is either a load (start symbol, rule entry for one level, leaf
// byte) or a query for one text position. busy stays low: the block takes a
// beat on every clock and each beat walks a fixed pipeline of
// 3*MAX_LEVELS+1 register stages.
// The first 2*MAX_LEVELS stages peel off the base-coverage digits of the
// position, one digit per two stages (reciprocal multiply, then remainder).
// After that come one table lookup per stage: the start store, one bank per
// rule level and the leaf store, each a single-port RAM with registered read.
// Loads write their store when they reach its stage, so they take effect in
// order with the queries around them. A query gives exactly one result beat,
// out_strobe high for one cycle, as it leaves the last stage; a load gives
// none. The receiver cannot hold results off. The stores are not
// cleared at reset: reading an entry never written returns whatever it holds.
// Configuration (coverage, level_count) may only be written while no query
// is in flight; cfg_ready is always high.
module grammar_tuple_random_access_core
  import gtra_pkg::*;
#(
  parameter int MAX_LEVELS      = 8,
  parameter int RULES_PER_LEVEL = 4096,
  parameter int START_DEPTH     = 4096,
  parameter int MAX_COVERAGE    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command side
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_op,
  input  wire logic [LVL_W-1:0]  in_level,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [SYM_W-1:0]  in_entry_value,
  input  wire logic [POS_W-1:0]  in_text_position,
  // result side
  output logic                   out_strobe,
  output logic [BYTE_W-1:0]      out_text_byte,
  output logic                   out_byte_valid,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int ML      = MAX_LEVELS;
  localparam int TD      = RULES_PER_LEVEL * MAX_COVERAGE;   // tuple store depth
  localparam int TAW     = $clog2(TD);
  localparam int SAW     = $clog2(START_DEPTH);
  localparam int DW      = $clog2(MAX_COVERAGE);              // digit width
  localparam int CVW     = $clog2(MAX_COVERAGE + 1);
  localparam int LVW     = $clog2(ML + 1);
  localparam int DIX_W   = (ML > 1) ? $clog2(ML) : 1;
  // Reciprocal scale: 2^K >= 2^32 * coverage makes the ceiling
  // reciprocal exact for every 32-bit dividend.
  localparam int K       = POS_W + $clog2(MAX_COVERAGE);
  localparam int PW      = POS_W + K;
  localparam int LATENCY = 3 * ML + 1;

  typedef struct packed {
    op_t                       op;
    logic [LVL_W-1:0]          lvl;
    logic [IDX_W-1:0]          idx;
    logic [SYM_W-1:0]          val;
    logic [POS_W-1:0]          x;     // remaining quotient, then start slot
    logic [ML-1:0][DW-1:0]     dig;   // digit i = i-th from least significant
    logic [SYM_W-1:0]          sym;
    logic                      dead;  // result already known invalid
    logic                      rd;    // this stage's RAM read is live
  } item_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and clamped values
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cov_r;
  logic [CFG_W-1:0] lev_r;
  logic [CVW-1:0]   cov_eff;
  logic [LVW-1:0]   lev_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r <= CFG_W'(2);
      lev_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COVERAGE:    cov_r <= cfg_data;
        REG_LEVEL_COUNT: lev_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cov_r) < 32'd2) begin
      cov_eff = CVW'(2);
    end else if (32'(cov_r) > MAX_COVERAGE) begin
      cov_eff = CVW'(MAX_COVERAGE);
    end else begin
      cov_eff = CVW'(cov_r);
    end
    if (lev_r == '0) begin
      lev_eff = LVW'(1);
    end else if (32'(lev_r) > ML) begin
      lev_eff = LVW'(ML);
    end else begin
      lev_eff = LVW'(lev_r);
    end
  end

  // Ceiling reciprocals, one per legal coverage
  logic [K-1:0] recip [2:MAX_COVERAGE];
  for (genvar c = 2; c <= MAX_COVERAGE; c++) begin : g_recip
    localparam longint RC = ((64'd1 << K) + c - 1) / c;
    assign recip[c] = K'(RC);
  end

  // ---------------------------------------------------------------------------
  // Input beat
  // ---------------------------------------------------------------------------
  logic  accept;
  item_t in_item;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    in_item      = '0;
    in_item.op   = op_t'(in_op);
    in_item.lvl  = in_level;
    in_item.idx  = in_entry_index;
    in_item.val  = in_entry_value;
    in_item.x    = in_text_position;
  end

  // ---------------------------------------------------------------------------
  // Digit stages: A multiplies by the reciprocal, B forms quotient and digit
  // ---------------------------------------------------------------------------
  item_t         da_r   [ML];
  logic          da_v_r [ML];
  logic [PW-1:0] prod_r [ML];
  item_t         db_r   [ML];
  logic          db_v_r [ML];

  for (genvar i = 0; i < ML; i++) begin : g_div
    item_t         a_in;
    logic          a_in_v;
    item_t         b_nxt;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] rem;

    if (i == 0) begin : g_first
      assign a_in   = in_item;
      assign a_in_v = accept;
    end else begin : g_chain
      assign a_in   = db_r[i-1];
      assign a_in_v = db_v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        da_v_r[i] <= 1'b0;
        db_v_r[i] <= 1'b0;
      end else begin
        da_v_r[i] <= a_in_v;
        db_v_r[i] <= da_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      da_r[i]   <= a_in;
      prod_r[i] <= PW'(a_in.x) * PW'(recip[cov_eff]);
      db_r[i]   <= b_nxt;
    end

    always_comb begin
      q     = prod_r[i][PW-1:K];
      rem   = da_r[i].x - POS_W'(q * POS_W'(cov_eff));
      b_nxt = da_r[i];
      if (32'(lev_eff) > i) begin
        b_nxt.x      = q;
        b_nxt.dig[i] = rem[DW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup stages: 0 = start store, 1..ML-1 = rule levels, then the leaf
  // ---------------------------------------------------------------------------
  item_t            lk_r       [ML];
  logic             lk_v_r     [ML];
  logic [SYM_W-1:0] lk_rdata   [ML];

  // start store
  item_t            st_nxt;
  logic             st_we;
  logic [31:0]      st_idx32;
  logic [SAW-1:0]   st_addr;

  always_comb begin
    st_idx32    = 32'(db_r[ML-1].idx);
    st_nxt      = db_r[ML-1];
    st_nxt.rd   = 1'b0;
    st_nxt.dead = 1'b0;
    st_we       = db_v_r[ML-1] && (db_r[ML-1].op == OP_START)
                  && (st_idx32 < START_DEPTH);
    if (db_r[ML-1].op == OP_QUERY) begin
      if (db_r[ML-1].x < 32'(START_DEPTH)) begin
        st_nxt.rd = 1'b1;
      end else begin
        st_nxt.dead = 1'b1;
      end
    end
    st_addr = st_we ? st_idx32[SAW-1:0] : db_r[ML-1].x[SAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_v_r[0] <= 1'b0;
    end else begin
      lk_v_r[0] <= db_v_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    lk_r[0] <= st_nxt;
  end

  gtra_ram #(
    .WIDTH (SYM_W),
    .DEPTH (START_DEPTH)
  ) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (db_r[ML-1].val),
    .rdata (lk_rdata[0])
  );

  // rule levels
  for (genvar j = 1; j < ML; j++) begin : g_rule
    item_t            pi;
    item_t            nxt;
    logic [SYM_W-1:0] sym_in;
    logic             dead_in;
    logic [DIX_W-1:0] di;
    logic [31:0]      addr32;
    logic [31:0]      idx32;
    logic             we;
    logic [TAW-1:0]   addr;

    assign pi = lk_r[j-1];

    always_comb begin
      sym_in  = pi.rd ? lk_rdata[j-1] : pi.sym;
      dead_in = pi.dead || (pi.rd && (lk_rdata[j-1] == '0));
      di      = DIX_W'(32'(lev_eff) - 32'(j));
      addr32  = (32'(sym_in) - 32'd1) * 32'(cov_eff) + 32'(pi.dig[di]);
      idx32   = 32'(pi.idx);
      nxt      = pi;
      nxt.sym  = sym_in;
      nxt.dead = dead_in;
      nxt.rd   = 1'b0;
      if ((pi.op == OP_QUERY) && (32'(lev_eff) > j) && !dead_in) begin
        if (addr32 < 32'(TD)) begin
          nxt.rd = 1'b1;
        end else begin
          nxt.dead = 1'b1;
        end
      end
      we   = lk_v_r[j-1] && (pi.op == OP_RULE) && (32'(pi.lvl) == j) && (idx32 < TD);
      addr = we ? idx32[TAW-1:0] : addr32[TAW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lk_v_r[j] <= 1'b0;
      end else begin
        lk_v_r[j] <= lk_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      lk_r[j] <= nxt;
    end

    gtra_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TD)
    ) u_rule_ram (
      .clk   (clk),
      .we    (we),
      .addr  (addr),
      .wdata (pi.val),
      .rdata (lk_rdata[j])
    );
  end

  // leaf store
  item_t             lf_pi;
  item_t             lf_nxt;
  item_t             lf_r;
  logic              lf_v_r;
  logic [SYM_W-1:0]  lf_sym;
  logic              lf_dead;
  logic [31:0]       lf_addr32;
  logic [31:0]       lf_idx32;
  logic              lf_we;
  logic [TAW-1:0]    lf_addr;
  logic [BYTE_W-1:0] lf_rdata;

  assign lf_pi = lk_r[ML-1];

  always_comb begin
    lf_sym    = lf_pi.rd ? lk_rdata[ML-1] : lf_pi.sym;
    lf_dead   = lf_pi.dead || (lf_pi.rd && (lk_rdata[ML-1] == '0));
    lf_addr32 = (32'(lf_sym) - 32'd1) * 32'(cov_eff) + 32'(lf_pi.dig[0]);
    lf_idx32  = 32'(lf_pi.idx);
    lf_nxt      = lf_pi;
    lf_nxt.sym  = lf_sym;
    lf_nxt.dead = lf_dead;
    lf_nxt.rd   = 1'b0;
    if ((lf_pi.op == OP_QUERY) && !lf_dead) begin
      if (lf_addr32 < 32'(TD)) begin
        lf_nxt.rd = 1'b1;
      end else begin
        lf_nxt.dead = 1'b1;
      end
    end
    lf_we   = lk_v_r[ML-1] && (lf_pi.op == OP_LEAF) && (lf_idx32 < TD);
    lf_addr = lf_we ? lf_idx32[TAW-1:0] : lf_addr32[TAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_v_r <= 1'b0;
    end else begin
      lf_v_r <= lk_v_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    lf_r <= lf_nxt;
  end

  gtra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TD)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (lf_we),
    .addr  (lf_addr),
    .wdata (lf_pi.val[BYTE_W-1:0]),
    .rdata (lf_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result beat
  // ---------------------------------------------------------------------------
  logic lf_ok;

  assign lf_ok          = !lf_r.dead && lf_r.rd && (lf_rdata != '0);
  assign out_strobe     = lf_v_r && (lf_r.op == OP_QUERY);
  assign out_byte_valid = out_strobe && lf_ok;
  assign out_text_byte  = out_byte_valid ? lf_rdata : '0;

`ifndef NO_ASSERTIONS
  // a query comes out after the fixed pipeline depth
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_QUERY)) |-> ##LATENCY out_strobe)
    else $error("query result missing at pipeline depth");

  // every result beat traces back to a query
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept && (in_op == OP_QUERY), LATENCY))
    else $error("result beat without a query");

  // a result either read the leaf or was already dropped
  a_leaf_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (lf_r.dead || lf_r.rd))
    else $error("result neither read nor dropped");

  // loads never issue a live leaf read
  a_load_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (lf_v_r && (lf_r.op != OP_QUERY)) |-> !lf_r.rd)
    else $error("load beat marked as live read");
`endif

endmodule
`default_nettype wire

@@ sim/grammar_tuple_random_access_core_test.sv @@
`timescale 1ns / 1ps
module grammar_tuple_random_access_core_test;
  import gtra_pkg::*;

  localparam int START_N   = 4096;
  localparam int TUPLE_N   = 32768;
  localparam int LEVELS_N  = 8;
  localparam int COV_N     = 8;
  // query walks 3*MAX_LEVELS+1 stages; leave some margin
  localparam int DRAIN_CYC = 40;
  localparam int CYC_LIMIT = 600000;

  typedef struct packed {
    op_t         op;
    logic [2:0]  lvl;
    logic [14:0] idx;
    logic [12:0] val;
    logic [31:0] pos;
  } beat_t;

  typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_t;

  // directed row: a beat or a register write; expected result typed in
  // only where chk is set
  typedef struct {
    row_kind_t   kind;
    beat_t       b;
    bit          chk;
    logic [7:0]  eb;
    logic        ev;
  } row_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
  } byte_res_t;

  logic clk, rst_n;
  logic start, busy;
  logic [1:0] in_op;
  logic [LVL_W-1:0] in_level;
  logic [IDX_W-1:0] in_entry_index;
  logic [SYM_W-1:0] in_entry_value;
  logic [POS_W-1:0] in_text_position;
  logic out_strobe;
  logic [BYTE_W-1:0] out_text_byte;
  logic out_byte_valid;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  grammar_tuple_random_access_core dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_level, .in_entry_index,
    .in_entry_value, .in_text_position, .out_strobe, .out_text_byte,
    .out_byte_valid, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- shadow of the grammar stores; an entry exists only once written ----
  logic [12:0] start_mem[int];
  logic [12:0] rule_mem[int];     // key: bank*TUPLE_N + address
  logic [7:0]  leaf_mem[int];
  logic [3:0]  cov_reg, lvl_reg;

  byte_res_t pending_bytes[$];
  int errors, n_queries, n_loads, n_results, n_phases;
  int cycles;
  bit nogap;

  function automatic int eff_cov();
    if (cov_reg < 2) return 2;
    if (cov_reg > COV_N) return COV_N;
    return cov_reg;
  endfunction

  function automatic int eff_lvl();
    if (lvl_reg < 1) return 1;
    if (lvl_reg > LEVELS_N) return LEVELS_N;
    return lvl_reg;
  endfunction

  function automatic longint text_span();
    longint s;
    s = 1;
    for (int j = 0; j < eff_lvl(); j++) s *= eff_cov();
    return s;
  endfunction

  // Walks the grammar for one position. Returns 0 when the walk would touch
  // an entry never written (such a query is never issued).
  function automatic bit decode_byte(input logic [31:0] pos, output byte_res_t r);
    longint cov, span, rem, slot, sym, addr;
    int lv;
    cov  = eff_cov();
    lv   = eff_lvl();
    span = text_span();
    r    = '0;
    slot = longint'(pos) / span;
    rem  = longint'(pos) % span;
    if (slot >= START_N) return 1;
    if (!start_mem.exists(int'(slot))) return 0;
    sym = start_mem[int'(slot)];
    if (sym == 0) return 1;
    for (int j = 1; j < lv; j++) begin
      span /= cov;
      addr = (sym - 1) * cov + rem / span;
      rem  = rem % span;
      if (addr >= TUPLE_N) return 1;
      if (!rule_mem.exists((j - 1) * TUPLE_N + int'(addr))) return 0;
      sym = rule_mem[(j - 1) * TUPLE_N + int'(addr)];
      if (sym == 0) return 1;
    end
    addr = (sym - 1) * cov + rem;
    if (addr >= TUPLE_N) return 1;
    if (!leaf_mem.exists(int'(addr))) return 0;
    if (leaf_mem[int'(addr)] == 0) return 1;
    r.text_byte  = leaf_mem[int'(addr)];
    r.byte_valid = 1'b1;
    return 1;
  endfunction

  // Applies one accepted beat to the shadow state, queueing a query's result.
  task automatic track_beat(beat_t b, bit chk, logic [7:0] eb, logic ev);
    byte_res_t r;
    case (b.op)
      OP_START: begin
        if (b.idx < START_N) start_mem[b.idx] = b.val;
        n_loads++;
      end
      OP_RULE: begin
        if (b.lvl >= 1 && b.lvl < LEVELS_N)
          rule_mem[(b.lvl - 1) * TUPLE_N + b.idx] = b.val;
        n_loads++;
      end
      OP_LEAF: begin
        leaf_mem[b.idx] = b.val[7:0];
        n_loads++;
      end
      OP_QUERY: begin
        if (chk) begin
          r.text_byte  = eb;
          r.byte_valid = ev;
        end else begin
          void'(decode_byte(b.pos, r));
        end
        pending_bytes = {pending_bytes, r};
        n_queries++;
      end
    endcase
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (nogap) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start stays high across back-to-back beats
  task automatic send_beat(beat_t b, bit chk = 0, logic [7:0] eb = '0, logic ev = 0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_op            <= b.op;
    in_level         <= b.lvl;
    in_entry_index   <= b.idx;
    in_entry_value   <= b.val;
    in_text_position <= b.pos;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    track_beat(b, chk, eb, ev);
  endtask

  // Register writes only when idle: no result pending, pipeline drained.
  task automatic write_reg(cfg_reg_t ri, logic [3:0] d);
    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (ri == REG_COVERAGE) cov_reg = d;
    else lvl_reg = d;
  endtask

  // ---- result checker: sampled mid-cycle, strobe is one cycle wide ----
  always @(negedge clk) begin
    byte_res_t e;
    if (rst_n && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        $error("result beat with nothing expected: byte %0h valid %0b",
               out_text_byte, out_byte_valid);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        n_results++;
        if (out_byte_valid !== e.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", e.byte_valid, out_byte_valid);
          errors++;
        end
        if (out_text_byte !== e.text_byte) begin
          $error("text_byte: expected %0h, got %0h", e.text_byte, out_text_byte);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---- directed table ----
  function automatic row_t mk(op_t op, int lvl, int idx, int val, longint pos,
                              bit chk = 0, int eb = 0, int ev = 0);
    row_t r;
    r.kind  = ROW_BEAT;
    r.b.op  = op;
    r.b.lvl = lvl;
    r.b.idx = idx;
    r.b.val = val;
    r.b.pos = pos[31:0];
    r.chk   = chk;
    r.eb    = eb;
    r.ev    = ev;
    return r;
  endfunction

  function automatic row_t mk_cfg(cfg_reg_t ri, int d);
    row_t r;
    r      = mk(OP_START, 0, 0, 0, 0);
    r.kind = ROW_CFG;
    r.b.idx = ri;
    r.b.val = d;
    return r;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  task automatic run_directed();
    // reset setting: coverage 2, one level
    add_row(mk(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0)); // start out of range
    add_row(mk(OP_START, 0, 0, 0, 0));
    add_row(mk(OP_QUERY, 0, 0, 0, 0, 1, 0, 0));             // empty start symbol
    add_row(mk(OP_START, 0, 4095, 4096, 0));
    add_row(mk(OP_LEAF, 0, 8190, 13'h1FF, 0));
    add_row(mk(OP_LEAF, 0, 8191, 13'h100, 0));             // stores byte 0
    add_row(mk(OP_QUERY, 0, 0, 0, 8190, 1, 8'hFF, 1));
    add_row(mk(OP_QUERY, 0, 0, 0, 8191, 1, 0, 0));          // padding byte
    add_row(mk(OP_LEAF, 0, 32767, 13'h1A5, 0));
    add_row(mk(OP_START, 0, 4096, 1, 0));                   // ignored
    add_row(mk(OP_START, 0, 32767, 8191, 0));               // ignored
    add_row(mk(OP_QUERY, 0, 0, 0, 8192, 1, 0, 0));
    add_row(mk_cfg(REG_COVERAGE, 8));
    add_row(mk(OP_START, 0, 3, 8191, 0));
    add_row(mk(OP_QUERY, 0, 0, 0, 3 * 8, 1, 0, 0));         // tuple out of range
    add_row(mk(OP_QUERY, 0, 0, 0, 32767, 1, 8'hA5, 1));     // last leaf entry
    add_row(mk_cfg(REG_LEVEL_COUNT, 2));
    add_row(mk(OP_RULE, 0, 0, 5, 0));                       // level 0 ignored
    add_row(mk(OP_RULE, 1, 0, 1, 0));
    add_row(mk(OP_RULE, 1, 1, 0, 0));
    add_row(mk(OP_RULE, 7, 32767, 4096, 0));
    add_row(mk(OP_START, 0, 5, 1, 0));
    add_row(mk(OP_LEAF, 0, 3, 13'h042, 0));
    add_row(mk(OP_QUERY, 0, 0, 0, 5 * 64 + 3, 1, 8'h42, 1));
    add_row(mk(OP_QUERY, 0, 0, 0, 5 * 64 + 8, 1, 0, 0));    // empty rule symbol
    // out-of-range register values clamp
    add_row(mk_cfg(REG_COVERAGE, 0));
    add_row(mk_cfg(REG_LEVEL_COUNT, 0));
    add_row(mk(OP_QUERY, 0, 0, 0, 8190));
    add_row(mk_cfg(REG_COVERAGE, 15));
    add_row(mk_cfg(REG_LEVEL_COUNT, 15));
    add_row(mk(OP_QUERY, 0, 0, 0, 32'h0300_0000));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(cfg_reg_t'(dir_rows[i].b.idx[0]), dir_rows[i].b.val[3:0]);
      else
        send_beat(dir_rows[i].b, dir_rows[i].chk, dir_rows[i].eb, dir_rows[i].ev);
    end
  endtask

  // ---- random phases ----
  function automatic beat_t noise_beat();
    beat_t b;
    b.op  = op_t'($urandom_range(0, 2));
    b.lvl = $urandom_range(0, 7);
    b.idx = $urandom;
    b.val = $urandom;
    b.pos = $urandom;
    return b;
  endfunction

  // Loads a small well-formed grammar under the current setting, then
  // queries it; noise loads and stray positions are mixed in.
  task automatic run_phase();
    int c, lv, k, nsym, base, n_q;
    longint span, maxslot, p;
    int syms[LEVELS_N + 1][$];
    beat_t b, loads[$];
    byte_res_t r;
    c    = eff_cov();
    lv   = eff_lvl();
    span = text_span();
    maxslot = 64'hFFFF_FFFF / span;
    if (maxslot > START_N - 1) maxslot = START_N - 1;
    k    = $urandom_range(1, 8);
    base = $urandom_range(0, int'(maxslot) - k + 1);
    for (int j = 1; j <= lv; j++) begin
      nsym = (lv > 4) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      for (int s = 0; s < nsym; s++)
        syms[j] = {syms[j], int'($urandom_range(1, TUPLE_N / c))};
    end
    b = noise_beat();
    for (int s = 0; s < k; s++) begin
      b.op  = OP_START;
      b.idx = base + s;
      b.val = ($urandom_range(0, 19) == 0) ? 0 : syms[1][$urandom % syms[1].size()];
      loads = {loads, b};
    end
    for (int j = 1; j < lv; j++)
      foreach (syms[j][s])
        for (int d = 0; d < c; d++) begin
          b.op  = OP_RULE;
          b.lvl = j;
          b.idx = (syms[j][s] - 1) * c + d;
          b.val = ($urandom_range(0, 24) == 0) ? 0 :
                  syms[j + 1][$urandom % syms[j + 1].size()];
          loads = {loads, b};
        end
    foreach (syms[lv][s])
      for (int d = 0; d < c; d++) begin
        b.op  = OP_LEAF;
        b.idx = (syms[lv][s] - 1) * c + d;
        b.val = $urandom;
        if ($urandom_range(0, 19) == 0) b.val[7:0] = 0;
        loads = {loads, b};
      end
    foreach (loads[i]) begin
      if ($urandom_range(0, 9) == 0) send_beat(noise_beat());
      send_beat(loads[i]);
    end
    n_q = $urandom_range(30, 60);
    for (int q = 0; q < n_q; q++) begin
      if ($urandom_range(0, 9) == 0) send_beat(noise_beat());
      b = noise_beat();
      b.op = OP_QUERY;
      for (int t = 0; t < 20; t++) begin
        case ($urandom_range(0, 9))
          0:       p = {$urandom};
          1:       p = (longint'(base) + k) * span - $urandom_range(0, 1);
          default: p = longint'(base) * span + ({$urandom} % (longint'(k) * span));
        endcase
        b.pos = p[31:0];
        if (decode_byte(b.pos, r)) break;
        b.pos = 32'hFFFF_FFFF;
        if (!decode_byte(b.pos, r)) b.op = OP_LEAF;  // drop to a harmless load
      end
      send_beat(b);
    end
    n_phases++;
  endtask

  initial begin
    int settings[$][2];
    int ph;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_START;
    in_level = '0;
    in_entry_index = '0;
    in_entry_value = '0;
    in_text_position = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COVERAGE;
    cfg_data = '0;
    cov_reg = 2;
    lvl_reg = 1;
    errors = 0;
    cycles = 0;
    nogap = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    settings = '{'{2, 1}, '{8, 8}, '{3, 3}, '{0, 0}, '{15, 15}, '{5, 2},
                 '{2, 8}, '{8, 1}, '{4, 4}, '{7, 5}, '{6, 7}};
    ph = 0;
    while (n_queries + n_loads < 800) begin
      if (ph < settings.size()) begin
        write_reg(REG_COVERAGE, settings[ph][0]);
        write_reg(REG_LEVEL_COUNT, settings[ph][1]);
      end else begin
        write_reg(REG_COVERAGE, $urandom_range(0, 15));
        write_reg(REG_LEVEL_COUNT, $urandom_range(0, 15));
      end
      nogap = ($urandom_range(0, 3) == 0);
      run_phase();
      ph++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d queries and %0d loads over %0d random grammars plus the directed table",
             n_queries, n_loads, n_phases);
    $display("%0d result beats checked in %0d cycles", n_results, cycles);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
